// ----- src/ddo_pkg.sv -----
// Shared types, constants and the sine table builder for the odometry block.
// Depends on nothing; used by the sine ROM and the top level.

package ddo_pkg;

    // Field and register widths
    localparam int TRAVEL_W = 32;
    localparam int POSE_W   = 32;
    localparam int GAIN_W   = 40;
    localparam int SINE_W   = 16;

    // Configuration reset and table defaults
    localparam logic [GAIN_W-1:0] GAIN_RESET      = 40'd683565276;
    localparam int                SINE_TABLE_BITS = 10;

    // Fixed-point constants for the table builder
    localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
    localparam longint unsigned ONE_Q30     = 64'd1073741824;
    localparam longint unsigned ROUND_Q30   = 64'd536870912;
    localparam longint unsigned SINE_MAX    = 64'd32767;

    // Sequencer states
    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_DIFF = 11'b000_0000_0010,
        S_MLO  = 11'b000_0000_0100,
        S_MHI  = 11'b000_0000_1000,
        S_HEAD = 11'b000_0001_0000,
        S_MID  = 11'b000_0010_0000,
        S_RSIN = 11'b000_0100_0000,
        S_RCOS = 11'b000_1000_0000,
        S_MCOS = 11'b001_0000_0000,
        S_POSX = 11'b010_0000_0000,
        S_OUT  = 11'b100_0000_0000
    } state_t;

    // Q1.15 sine of entry r within a quarter turn of 2^qbits steps.
    // Odd Taylor series to degree 13 in Horner form, Q30 truncation.
    function automatic logic [SINE_W-1:0] sine_q15(input int unsigned r,
                                                   input int unsigned qbits);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned p;
        longint unsigned s;
        longint unsigned v;
        int              i;
        x  = (longint'(r) * PI_HALF_Q30) >> qbits;
        x2 = (x * x) >> 30;
        t  = ONE_Q30;
        for (i = 0; i < 6; i++) begin
            p = (x2 * t) >> 30;
            case (i)
                0:       t = ONE_Q30 - p / 156;
                1:       t = ONE_Q30 - p / 110;
                2:       t = ONE_Q30 - p / 72;
                3:       t = ONE_Q30 - p / 42;
                4:       t = ONE_Q30 - p / 20;
                default: t = ONE_Q30 - p / 6;
            endcase
        end
        s = (x * t) >> 30;
        v = (s * SINE_MAX + ROUND_Q30) >> 30;
        if (v > SINE_MAX) begin
            v = SINE_MAX;
        end
        return SINE_W'(v);
    endfunction

endpackage

// ----- src/ddo_sine_rom.sv -----
// Registered sine ROM: quarter-wave table folded to a full turn.
// Depends on ddo_pkg for the table builder and widths.

module ddo_sine_rom #(
    parameter int TABLE_BITS = ddo_pkg::SINE_TABLE_BITS
) (
    input  logic                              aclk,
    input  logic [TABLE_BITS-1:0]             rd_index,
    output logic signed [ddo_pkg::SINE_W-1:0] rd_data
);

    localparam int QBITS = TABLE_BITS - 2;
    localparam int QSIZE = 2 ** QBITS;

    logic [ddo_pkg::SINE_W-1:0] sine_tbl [0:QSIZE];
    logic [1:0]                 quad;
    logic [QBITS-1:0]           offs;
    logic [QBITS:0]             fold_idx;
    logic [ddo_pkg::SINE_W-1:0] mag;
    logic signed [ddo_pkg::SINE_W-1:0] data_reg;

    // Build the quarter-wave table at elaboration
    for (genvar g = 0; g <= QSIZE; g++) begin : g_tbl
        assign sine_tbl[g] = ddo_pkg::sine_q15(g, QBITS);
    end

    // Fold the index into the first quarter
    assign quad     = rd_index[TABLE_BITS-1 -: 2];
    assign offs     = rd_index[QBITS-1:0];
    assign fold_idx = quad[0] ? ((QBITS+1)'(QSIZE) - {1'b0, offs}) : {1'b0, offs};
    assign mag      = sine_tbl[fold_idx];

    // Register the read, negate in the second half turn
    always_ff @(posedge aclk) begin
        data_reg <= quad[1] ? -$signed(mag) : $signed(mag);
    end

    assign rd_data = data_reg;

endmodule

// ----- src/differential_drive_odometry.sv -----
// Differential-drive dead-reckoning odometry, top level.
// Depends on ddo_pkg and ddo_sine_rom.
//
// One item (cumulative left and right wheel travel) yields one pose item.
// The block takes one item at a time: s_ready returns the cycle after the
// pose is taken. The sequencer passes four products (two halves of the
// heading-gain product, then travel times sine and travel times cosine)
// through one registered 33x21 multiplier, and each projection is preceded
// by a registered sine ROM read. heading_gain may be written only while
// the block is idle; it takes effect on the next item.

module differential_drive_odometry #(
    parameter int SINE_TABLE_BITS = ddo_pkg::SINE_TABLE_BITS
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // configuration
    input  logic                                 cfg_wr_en,
    input  logic [ddo_pkg::GAIN_W-1:0]           cfg_wr_data,
    // input items
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [ddo_pkg::TRAVEL_W-1:0]  s_left_travel,
    input  logic signed [ddo_pkg::TRAVEL_W-1:0]  s_right_travel,
    // result items
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [ddo_pkg::POSE_W-1:0]    m_pose_x,
    output logic signed [ddo_pkg::POSE_W-1:0]    m_pose_y,
    output logic [ddo_pkg::POSE_W-1:0]           m_pose_heading
);

    localparam int TW    = ddo_pkg::TRAVEL_W;
    localparam int PW    = ddo_pkg::POSE_W;
    localparam int SW    = ddo_pkg::SINE_W;
    localparam int GHALF = ddo_pkg::GAIN_W / 2;
    localparam int MA_W  = TW + 1;
    localparam int MB_W  = GHALF + 1;
    localparam int MP_W  = MA_W + MB_W;
    localparam int PR_W  = 49;
    localparam int QTURN = 2 ** (SINE_TABLE_BITS - 2);

    ddo_pkg::state_t state_reg, state_next;

    logic [ddo_pkg::GAIN_W-1:0]  gain_reg;
    logic [TW-1:0]               last_left_reg;
    logic [TW-1:0]               last_right_reg;
    logic [TW-1:0]               dl_reg;
    logic [TW-1:0]               dr_reg;
    logic signed [MA_W-1:0]      diff_reg;
    logic signed [TW-1:0]        travel_reg;
    logic signed [MP_W-1:0]      mul_reg;
    logic [PR_W-1:0]             prod_reg;
    logic [PW-1:0]               heading_reg;
    logic [PW-1:0]               mid_reg;
    logic signed [PW-1:0]        pos_x_reg;
    logic signed [PW-1:0]        pos_y_reg;
    logic                        m_valid_reg;

    logic signed [MA_W-1:0]      mul_a;
    logic signed [MB_W-1:0]      mul_b;
    logic signed [MA_W:0]        step_sum;
    logic signed [SW-1:0]        rom_data;
    logic [SINE_TABLE_BITS-1:0]  sin_idx;
    logic [SINE_TABLE_BITS-1:0]  cos_idx;
    logic [SINE_TABLE_BITS-1:0]  rom_idx;
    logic signed [PW-1:0]        pos_sel;
    logic signed [PW+1:0]        pos_sum;
    logic signed [PW-1:0]        pos_sat;
    logic                        in_fire;

    assign in_fire = s_valid && s_ready;

    // Sine ROM shared by the sine and cosine lookups
    assign sin_idx = mid_reg[PW-1 -: SINE_TABLE_BITS];
    assign cos_idx = sin_idx + SINE_TABLE_BITS'(QTURN);
    assign rom_idx = (state_reg == ddo_pkg::S_RSIN) ? sin_idx : cos_idx;

    ddo_sine_rom #(
        .TABLE_BITS(SINE_TABLE_BITS)
    ) u_rom (
        .aclk     (aclk),
        .rd_index (rom_idx),
        .rd_data  (rom_data)
    );

    // Select multiplier operands for the current step
    always_comb begin
        case (state_reg)
            ddo_pkg::S_MLO: begin
                mul_a = diff_reg;
                mul_b = $signed({1'b0, gain_reg[GHALF-1:0]});
            end
            ddo_pkg::S_MHI: begin
                mul_a = diff_reg;
                mul_b = $signed({1'b0, gain_reg[ddo_pkg::GAIN_W-1:GHALF]});
            end
            default: begin
                mul_a = {travel_reg[TW-1], travel_reg};
                mul_b = {{(MB_W-SW){rom_data[SW-1]}}, rom_data};
            end
        endcase
    end

    // Wheel step sum, halved by floor
    assign step_sum = {{2{dl_reg[TW-1]}}, dl_reg} + {{2{dr_reg[TW-1]}}, dr_reg};

    // Saturating position update, shared by y then x
    assign pos_sel = (state_reg == ddo_pkg::S_MCOS) ? pos_y_reg : pos_x_reg;
    assign pos_sum = {{2{pos_sel[PW-1]}}, pos_sel}
                   + {mul_reg[47], mul_reg[47:15]};
    always_comb begin
        if (pos_sum > $signed((PW+2)'(34'sh0_7FFF_FFFF))) begin
            pos_sat = {1'b0, {(PW-1){1'b1}}};
        end else if (pos_sum < -$signed((PW+2)'(34'sh0_8000_0000))) begin
            pos_sat = {1'b1, {(PW-1){1'b0}}};
        end else begin
            pos_sat = pos_sum[PW-1:0];
        end
    end

    // Advance the sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ddo_pkg::S_IDLE: if (s_valid) begin
                state_next = ddo_pkg::S_DIFF;
            end
            ddo_pkg::S_DIFF: state_next = ddo_pkg::S_MLO;
            ddo_pkg::S_MLO:  state_next = ddo_pkg::S_MHI;
            ddo_pkg::S_MHI:  state_next = ddo_pkg::S_HEAD;
            ddo_pkg::S_HEAD: state_next = ddo_pkg::S_MID;
            ddo_pkg::S_MID:  state_next = ddo_pkg::S_RSIN;
            ddo_pkg::S_RSIN: state_next = ddo_pkg::S_RCOS;
            ddo_pkg::S_RCOS: state_next = ddo_pkg::S_MCOS;
            ddo_pkg::S_MCOS: state_next = ddo_pkg::S_POSX;
            ddo_pkg::S_POSX: state_next = ddo_pkg::S_OUT;
            ddo_pkg::S_OUT: if (m_ready) begin
                state_next = ddo_pkg::S_IDLE;
            end
            default: state_next = ddo_pkg::S_IDLE;
        endcase
    end

    // Control and architectural state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ddo_pkg::S_IDLE;
            gain_reg       <= ddo_pkg::GAIN_RESET;
            last_left_reg  <= '0;
            last_right_reg <= '0;
            heading_reg    <= '0;
            pos_x_reg      <= '0;
            pos_y_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                gain_reg <= cfg_wr_data;
            end
            if (in_fire) begin
                last_left_reg  <= s_left_travel;
                last_right_reg <= s_right_travel;
            end
            if (state_reg == ddo_pkg::S_MID) begin
                heading_reg <= heading_reg + prod_reg[47:16];
            end
            if (state_reg == ddo_pkg::S_MCOS) begin
                pos_y_reg <= pos_sat;
            end
            if (state_reg == ddo_pkg::S_POSX) begin
                pos_x_reg   <= pos_sat;
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        mul_reg <= mul_a * mul_b;
        if (in_fire) begin
            dl_reg <= s_left_travel - last_left_reg;
            dr_reg <= s_right_travel - last_right_reg;
        end
        if (state_reg == ddo_pkg::S_DIFF) begin
            diff_reg   <= {dr_reg[TW-1], dr_reg} - {dl_reg[TW-1], dl_reg};
            travel_reg <= step_sum[TW:1];
        end
        if (state_reg == ddo_pkg::S_MHI) begin
            prod_reg <= mul_reg[PR_W-1:0];
        end
        if (state_reg == ddo_pkg::S_HEAD) begin
            prod_reg <= prod_reg + {mul_reg[PR_W-GHALF-1:0], {GHALF{1'b0}}};
        end
        if (state_reg == ddo_pkg::S_MID) begin
            mid_reg <= heading_reg + prod_reg[48:17];
        end
    end

    assign s_ready        = (state_reg == ddo_pkg::S_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_pose_x       = pos_x_reg;
    assign m_pose_y       = pos_y_reg;
    assign m_pose_heading = heading_reg;

endmodule
